@@ rtl/coefficient_log_distance_accumulator_top_macros.svh @@
// Assertion macros for the coefficient log-distance accumulator checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef COEFFICIENT_LOG_DISTANCE_ACCUMULATOR_TOP_MACROS_SVH
`define COEFFICIENT_LOG_DISTANCE_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CLDA_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("clda assertion failed");

// Next-cycle implication, disabled while in reset
`define CLDA_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("clda assertion failed");

`endif

@@ rtl/clda_pkg.sv @@
// Package for the coefficient log-distance accumulator: widths, mode codes and
// the constant ln and row-weight tables built at elaboration. No dependencies.
`default_nettype none

package clda_pkg;

	// Fixed formats
	localparam int MAX_ROWS      = 1024;
	localparam int FRACTION_BITS = 16;
	localparam int LN_TABLE_BITS = 8;

	localparam int COEFF_W     = 32;
	localparam int ROW_W       = 10;
	localparam int ROW_COUNT_W = 11;
	localparam int MODE_W      = 2;
	localparam int SUM_W       = 48;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = ROW_COUNT_W;

	// |a-b|+1 reaches 2^32, so it needs one bit more than a coefficient
	localparam int X_W         = COEFF_W + 1;
	localparam int K_W         = $clog2(X_W);
	localparam int INT_TAB_N   = X_W;
	localparam int FRAC_TAB_N  = 1 << LN_TABLE_BITS;

	// ln(2^32) is about 1.45e6 in Q16, so 21 bits hold every log value
	localparam int LN_W        = 21;
	localparam int FRAC_W      = FRACTION_BITS;
	localparam int WEIGHT_W    = FRACTION_BITS + 1;
	localparam int PROD_W      = LN_W + WEIGHT_W;
	localparam int TERM_W      = PROD_W - FRACTION_BITS;
	localparam int ROW_R_W     = $clog2(MAX_ROWS + 1);

	// Weights for r up to 256 come from a table; above it the weight is 0 or 1
	localparam int W_IDX_W     = 8;
	localparam int W_TAB_N     = 1 << W_IDX_W;

	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOG      = 2'd0,
		MODE_ROW_LOG  = 2'd1,
		MODE_ONE_ZERO = 2'd2,
		MODE_ZERO_ONE = 2'd3
	} mode_t;

	// Control that travels with each pipeline stage
	typedef struct packed {
		logic  valid;
		logic  last;
		mode_t mode;
	} stage_ctl_t;

	typedef logic [LN_W-1:0]     int_tab_t    [INT_TAB_N];
	typedef logic [FRAC_W-1:0]   frac_tab_t   [FRAC_TAB_N];
	typedef logic [WEIGHT_W-1:0] weight_tab_t [W_TAB_N];

	// k*ln2 in Q(FRACTION_BITS), rounded half up
	function automatic int_tab_t build_int_tab();
		int_tab_t    t;
		logic [63:0] p;
		for (int k = 0; k < INT_TAB_N; k++) begin
			p = 64'(k) * LN2_Q32 + (64'd1 << (31 - FRACTION_BITS));
			p = p >> (32 - FRACTION_BITS);
			t[k] = p[LN_W-1:0];
		end
		return t;
	endfunction

	// ln(1 + f/2^L) by repeated squaring for log2 bits, then scaled by ln2
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t   t;
		logic [63:0] m;
		logic [63:0] g;
		logic [63:0] p;
		for (int f = 0; f < FRAC_TAB_N; f++) begin
			m = (64'd1 << 30) + (64'(f) << (30 - LN_TABLE_BITS));
			g = 64'd0;
			for (int i = 0; i < 32; i++) begin
				m = (m * m) >> 30;
				g = g << 1;
				if (m >= (64'd1 << 31)) begin
					g = g | 64'd1;
					m = m >> 1;
				end
			end
			p = (g * LN2_Q32 + (64'd1 << (63 - FRACTION_BITS))) >> (64 - FRACTION_BITS);
			t[f] = p[FRAC_W-1:0];
		end
		return t;
	endfunction

	// Rounded 1/r^2 for r = index+1, by shift-and-subtract division
	function automatic weight_tab_t build_weight_tab();
		weight_tab_t t;
		logic [63:0] sq;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] q;
		for (int i = 0; i < W_TAB_N; i++) begin
			sq  = 64'(i + 1) * 64'(i + 1);
			num = (64'd1 << FRACTION_BITS) + (sq >> 1);
			rem = 64'd0;
			q   = 64'd0;
			for (int b = 39; b >= 0; b--) begin
				rem = (rem << 1) | 64'(num[b]);
				if (rem >= sq) begin
					rem  = rem - sq;
					q[b] = 1'b1;
				end
			end
			t[i] = q[WEIGHT_W-1:0];
		end
		return t;
	endfunction

	// Largest r with r^2 <= 2^(F+1): the weight is 1 up to here and 0 beyond
	function automatic int row_one_limit();
		int r;
		r = 1;
		while (64'(r + 1) * 64'(r + 1) <= (64'd1 << (FRACTION_BITS + 1)))
			r = r + 1;
		return r;
	endfunction

	localparam int_tab_t    INT_TAB     = build_int_tab();
	localparam frac_tab_t   FRAC_TAB    = build_frac_tab();
	localparam weight_tab_t WEIGHT_TAB  = build_weight_tab();
	localparam int          ROW_ONE_MAX = row_one_limit();

endpackage

`default_nettype wire

@@ rtl/clda_if.sv @@
// Valid/ready channel interfaces for coefficient pairs and distance results.
// Depends on clda_pkg for field widths.
`default_nettype none

interface clda_in_if;
	logic                              valid;
	logic                              ready;
	logic [clda_pkg::COEFF_W-1:0]      coeff_a;
	logic [clda_pkg::COEFF_W-1:0]      coeff_b;
	logic [clda_pkg::ROW_W-1:0]        row_index;
	logic                              last_pair;

	modport source (output valid, coeff_a, coeff_b, row_index, last_pair, input ready);
	modport sink   (input valid, coeff_a, coeff_b, row_index, last_pair, output ready);
endinterface

interface clda_out_if;
	logic                              valid;
	logic                              ready;
	logic [clda_pkg::SUM_W-1:0]        distance;
	logic                              saturated;

	modport source (output valid, distance, saturated, input ready);
	modport sink   (input valid, distance, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/coefficient_log_distance_accumulator_top.sv @@
// Top level of the coefficient log-distance accumulator: config registers,
// five-stage pair pipeline and accumulator. Depends on clda_pkg, clda_if,
// clda_norm, clda_weight and clda_accum.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-------------
//   in_ch    | in  | coeff_a, coeff_b, row_index, last_pair    | valid/ready
//   out_ch   | out | distance, saturated                       | valid/ready
//   cfg      | in  | cfg_index, cfg_data                       | cfg_we only
//
// One pair is taken every cycle while ready is high. A final pair's result
// reaches the output register through the input register and the stages for
// difference, leading-one search, log table add, weight multiply and the
// saturating add. Ready falls only while a final pair waits behind an untaken
// result; then the whole pipeline holds. Reset clears the stage valids, the
// running sum, the clip flag and sets mode 0 with a row count of one.
`default_nettype none

module coefficient_log_distance_accumulator_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	clda_in_if.sink                                in_ch,
	clda_out_if.source                             out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [clda_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [clda_pkg::CFG_DATA_W-1:0]   cfg_data
);

	clda_pkg::mode_t                        mode_q;
	logic [clda_pkg::ROW_COUNT_W-1:0]       row_count_q;
	logic                                   advance;

	// Stage 1: input register
	clda_pkg::stage_ctl_t                   ctl_s1;
	logic [clda_pkg::COEFF_W-1:0]           a_s1;
	logic [clda_pkg::COEFF_W-1:0]           b_s1;
	logic [clda_pkg::ROW_W-1:0]             row_s1;

	// Stage 2: difference, hit flag, clamped row
	clda_pkg::stage_ctl_t                   ctl_s2;
	logic [clda_pkg::X_W-1:0]               x_s2;
	logic                                   hit_s2;
	logic [clda_pkg::ROW_R_W-1:0]           r_s2;

	// Stage 3: leading one, mantissa, weight
	clda_pkg::stage_ctl_t                   ctl_s3;
	logic [clda_pkg::K_W-1:0]               k_s3;
	logic [clda_pkg::LN_TABLE_BITS-1:0]     f_s3;
	logic [clda_pkg::WEIGHT_W-1:0]          w_s3;
	logic                                   hit_s3;

	// Stage 4: log value
	clda_pkg::stage_ctl_t                   ctl_s4;
	logic [clda_pkg::LN_W-1:0]              ln_s4;
	logic [clda_pkg::WEIGHT_W-1:0]          w_s4;
	logic                                   hit_s4;

	// Stage 5: term for the accumulator
	clda_pkg::stage_ctl_t                   ctl_s5;
	logic [clda_pkg::TERM_W-1:0]            term_s5;

	logic [clda_pkg::COEFF_W-1:0]           diff;
	logic [clda_pkg::ROW_R_W-1:0]           r_raw;
	logic [clda_pkg::ROW_R_W-1:0]           r_clamp;
	logic                                   hit;
	logic [clda_pkg::K_W-1:0]               k;
	logic [clda_pkg::LN_TABLE_BITS-1:0]     f;
	logic [clda_pkg::WEIGHT_W-1:0]          w;
	logic [clda_pkg::PROD_W-1:0]            prod;
	logic [clda_pkg::PROD_W-1:0]            prod_rnd;
	logic [clda_pkg::TERM_W-1:0]            term;

	assign in_ch.ready = advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= clda_pkg::MODE_LOG;
			row_count_q <= clda_pkg::ROW_COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				clda_pkg::CFG_MODE:
					mode_q <= clda_pkg::mode_t'(cfg_data[clda_pkg::MODE_W-1:0]);
				clda_pkg::CFG_ROW_COUNT:
					row_count_q <= cfg_data[clda_pkg::ROW_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids advance together; a held stage keeps its beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (advance) begin
			ctl_s1 <= '{valid: in_ch.valid, last: in_ch.last_pair, mode: mode_q};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Absolute difference, count hit and row number for the weight
	assign diff  = (a_s1 >= b_s1) ? (a_s1 - b_s1) : (b_s1 - a_s1);
	assign r_raw = (row_s1 == '0) ? row_count_q : clda_pkg::ROW_R_W'(row_s1);

	always_comb begin
		if (r_raw == '0)
			r_clamp = clda_pkg::ROW_R_W'(1);
		else if (r_raw > clda_pkg::ROW_R_W'(clda_pkg::MAX_ROWS))
			r_clamp = clda_pkg::ROW_R_W'(clda_pkg::MAX_ROWS);
		else
			r_clamp = r_raw;
	end

	always_comb begin
		if (ctl_s1.mode == clda_pkg::MODE_ONE_ZERO)
			hit = (a_s1 == clda_pkg::COEFF_W'(1)) && (b_s1 == '0);
		else
			hit = (a_s1 == '0) && (b_s1 == clda_pkg::COEFF_W'(1));
	end

	clda_norm u_norm (
		.x (x_s2),
		.k (k),
		.f (f)
	);

	clda_weight u_weight (
		.r (r_s2),
		.w (w)
	);

	// Term selection: plain log, weighted log rounded back to Q16, or a count
	assign prod     = clda_pkg::PROD_W'(ln_s4) * clda_pkg::PROD_W'(w_s4);
	assign prod_rnd = prod + (clda_pkg::PROD_W'(1) << (clda_pkg::FRACTION_BITS - 1));

	always_comb begin
		case (ctl_s4.mode)
			clda_pkg::MODE_LOG:
				term = clda_pkg::TERM_W'(ln_s4);
			clda_pkg::MODE_ROW_LOG:
				term = prod_rnd[clda_pkg::FRACTION_BITS +: clda_pkg::TERM_W];
			clda_pkg::MODE_ONE_ZERO, clda_pkg::MODE_ZERO_ONE:
				term = clda_pkg::TERM_W'(hit_s4);
			default:
				term = '0;
		endcase
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1    <= in_ch.coeff_a;
			b_s1    <= in_ch.coeff_b;
			row_s1  <= in_ch.row_index;
			x_s2    <= {1'b0, diff} + clda_pkg::X_W'(1);
			hit_s2  <= hit;
			r_s2    <= r_clamp;
			k_s3    <= k;
			f_s3    <= f;
			w_s3    <= w;
			hit_s3  <= hit_s2;
			ln_s4   <= clda_pkg::INT_TAB[k_s3] + clda_pkg::LN_W'(clda_pkg::FRAC_TAB[f_s3]);
			w_s4    <= w_s3;
			hit_s4  <= hit_s3;
			term_s5 <= term;
		end
	end

	clda_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s5),
		.term      (term_s5),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.distance  (out_ch.distance),
		.saturated (out_ch.saturated),
		.advance   (advance)
	);

endmodule

`default_nettype wire

@@ rtl/clda_norm.sv @@
// Leading-one search and mantissa extraction for ln(x), x = |a-b| + 1.
// Depends on clda_pkg.
`default_nettype none

module clda_norm (
	input  wire logic [clda_pkg::X_W-1:0]           x,
	output logic      [clda_pkg::K_W-1:0]           k,
	output logic      [clda_pkg::LN_TABLE_BITS-1:0] f
);

	logic [clda_pkg::X_W-1:0] x_norm;
	logic [clda_pkg::K_W-1:0] shift;

	// Find the leading one: the highest set bit wins
	always_comb begin
		k = '0;
		for (int i = 0; i < clda_pkg::X_W; i++) begin
			if (x[i])
				k = clda_pkg::K_W'(i);
		end
	end

	// Move the leading one to the top; the bits below it give the table index
	assign shift  = clda_pkg::K_W'(clda_pkg::X_W - 1) - k;
	assign x_norm = x << shift;
	assign f      = x_norm[clda_pkg::X_W-2 -: clda_pkg::LN_TABLE_BITS];

endmodule

`default_nettype wire

@@ rtl/clda_weight.sv @@
// Row weight 1/r^2 in Q16 for a clamped row number r in 1..MAX_ROWS.
// Depends on clda_pkg for the weight table.
`default_nettype none

module clda_weight (
	input  wire logic [clda_pkg::ROW_R_W-1:0]  r,
	output logic      [clda_pkg::WEIGHT_W-1:0] w
);

	logic [clda_pkg::ROW_R_W-1:0] r_m1;

	assign r_m1 = r - clda_pkg::ROW_R_W'(1);

	// Small rows read the table; large rows round to one or to zero
	always_comb begin
		if (r <= clda_pkg::ROW_R_W'(clda_pkg::W_TAB_N))
			w = clda_pkg::WEIGHT_TAB[r_m1[clda_pkg::W_IDX_W-1:0]];
		else if (r <= clda_pkg::ROW_R_W'(clda_pkg::ROW_ONE_MAX))
			w = clda_pkg::WEIGHT_W'(1);
		else
			w = '0;
	end

endmodule

`default_nettype wire

@@ rtl/clda_accum.sv @@
// Saturating 48-bit distance accumulator with the result output register.
// Depends on clda_pkg.
`default_nettype none

module clda_accum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire clda_pkg::stage_ctl_t          ctl,
	input  wire logic [clda_pkg::TERM_W-1:0]   term,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic      [clda_pkg::SUM_W-1:0]    distance,
	output logic                               saturated,
	output logic                               advance
);

	logic [clda_pkg::SUM_W-1:0] sum_q;
	logic                       clip_q;
	logic [clda_pkg::SUM_W:0]   sum_ext;
	logic [clda_pkg::SUM_W-1:0] sum_next;
	logic                       clip_next;
	logic                       take;

	// Stall only when a final beat would overwrite an untaken result
	assign advance = !(ctl.valid && ctl.last && out_valid && !out_ready);
	assign take    = advance && ctl.valid;

	// Add with carry out; a carry means the sum clips at all ones
	assign sum_ext   = {1'b0, sum_q} + (clda_pkg::SUM_W + 1)'(term);
	assign sum_next  = sum_ext[clda_pkg::SUM_W] ? '1 : sum_ext[clda_pkg::SUM_W-1:0];
	assign clip_next = clip_q || sum_ext[clda_pkg::SUM_W];

	// Accumulate, and on the final pair move the sum to the output and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			clip_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take && ctl.last)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (take) begin
				if (ctl.last) begin
					sum_q     <= '0;
					clip_q    <= 1'b0;
				end else begin
					sum_q     <= sum_next;
					clip_q    <= clip_next;
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && ctl.last) begin
			distance  <= sum_next;
			saturated <= clip_next;
		end
	end

endmodule

`default_nettype wire

@@ rtl/clda_checker.sv @@
// Port-level checks for the coefficient log-distance accumulator, bound to
// the top level. Depends on clda_pkg and the assertion macro header.
`default_nettype none
`include "coefficient_log_distance_accumulator_top_macros.svh"

module clda_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_ready,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [clda_pkg::SUM_W-1:0]    distance,
	input  wire logic                          saturated
);

	// A stalled result beat holds its payload
	`CLDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance) && $stable(saturated))

	// A clipped sum is pinned at its maximum
	`CLDA_ASSERT_IMPL(a_sat_max, out_valid && saturated, &distance)

	// Input back-pressure only comes from an untaken result
	`CLDA_ASSERT_IMPL(a_ready_cause, !in_ready, out_valid && !out_ready)

endmodule

bind coefficient_log_distance_accumulator_top clda_checker u_clda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.distance  (out_ch.distance),
	.saturated (out_ch.saturated)
);

`default_nettype wire
